/* rtl/rchpf_pkg.sv */
// Shared types, constants and tables for the hopping packet framer.
package rchpf_pkg;

  localparam int NUM_LANES    = 8;
  localparam int STICK_W      = 11;
  localparam int SW_W         = 4;
  localparam int PACKET_BYTES = 21;
  localparam int IDX_W        = 5;
  localparam int IN_W         = 96;
  localparam int OUT_W        = 56;
  localparam int USER_W       = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_W        = 32;
  localparam int HOP_W        = 4;
  localparam int SEQ_W        = 4;
  localparam int BIND_W       = 12;

  localparam int CHAN_MAX_DEF = 500;
  localparam int CHAN_W       = 15;
  localparam int MAG_W        = 19;
  localparam int RECIP_W      = MAG_W + 1;
  localparam int SCALE_MUL    = 'h1f1;
  localparam logic [MAG_W-1:0] STICK_OFS = MAG_W'('h5d9);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PACKET_BYTES - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_ID      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VARIANT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIND    = 2'd2;

  localparam logic [1:0] VAR_NONE = 2'd0;
  localparam logic [1:0] VAR_V9X9 = 2'd1;
  localparam logic [1:0] VAR_V6X6 = 2'd2;
  localparam logic [1:0] VAR_V912 = 2'd3;

  localparam logic [BIND_W-1:0] BIND_DEF = 12'd2500;
  localparam logic [SEQ_W-1:0]  SEQ_LAST = 4'd9;

  localparam logic [7:0] HDR_BIND  = 8'haa;
  localparam logic [7:0] HDR_DATA  = 8'h55;
  localparam logic [7:0] BIND_CHAN = 8'h01;
  localparam logic [7:0] ID_ADJ    = 8'h70;
  localparam logic [3:0] ID_NIB_MAX = 4'h9;

  localparam logic [7:0] SEQ_BYTE_0 = 8'h14;
  localparam logic [7:0] SEQ_BYTE_1 = 8'h31;
  localparam logic [7:0] SEQ_BYTE_2 = 8'h40;
  localparam logic [7:0] SEQ_BYTE_N = 8'h49;

  typedef logic [PACKET_BYTES-1:0][7:0] bytes_t;

  typedef struct packed {
    bytes_t      bytes;
    logic [7:0]  rf_channel;
    logic        binding;
    logic        refresh_power;
    logic [31:0] packet_count;
  } pkt_t;

  localparam logic [7:0] HOP_TABLE [256] = '{
    8'h0a,8'h5a,8'h14,8'h64,8'h1e,8'h6e,8'h28,8'h78,8'h32,8'h82,8'h3c,8'h8c,8'h46,8'h96,8'h50,8'ha0,
    8'ha0,8'h50,8'h96,8'h46,8'h8c,8'h3c,8'h82,8'h32,8'h78,8'h28,8'h6e,8'h1e,8'h64,8'h14,8'h5a,8'h0a,
    8'h0a,8'h5a,8'h50,8'ha0,8'h14,8'h64,8'h46,8'h96,8'h1e,8'h6e,8'h3c,8'h8c,8'h28,8'h78,8'h32,8'h82,
    8'h82,8'h32,8'h78,8'h28,8'h8c,8'h3c,8'h6e,8'h1e,8'h96,8'h46,8'h64,8'h14,8'ha0,8'h50,8'h5a,8'h0a,
    8'h28,8'h78,8'h0a,8'h5a,8'h50,8'ha0,8'h14,8'h64,8'h1e,8'h6e,8'h3c,8'h8c,8'h32,8'h82,8'h46,8'h96,
    8'h96,8'h46,8'h82,8'h32,8'h8c,8'h3c,8'h6e,8'h1e,8'h64,8'h14,8'ha0,8'h50,8'h5a,8'h0a,8'h78,8'h28,
    8'h50,8'ha0,8'h28,8'h78,8'h0a,8'h5a,8'h1e,8'h6e,8'h3c,8'h8c,8'h32,8'h82,8'h46,8'h96,8'h14,8'h64,
    8'h64,8'h14,8'h96,8'h46,8'h82,8'h32,8'h8c,8'h3c,8'h6e,8'h1e,8'h5a,8'h0a,8'h78,8'h28,8'ha0,8'h50,
    8'h50,8'ha0,8'h46,8'h96,8'h3c,8'h8c,8'h28,8'h78,8'h0a,8'h5a,8'h32,8'h82,8'h1e,8'h6e,8'h14,8'h64,
    8'h64,8'h14,8'h6e,8'h1e,8'h82,8'h32,8'h5a,8'h0a,8'h78,8'h28,8'h8c,8'h3c,8'h96,8'h46,8'ha0,8'h50,
    8'h46,8'h96,8'h3c,8'h8c,8'h50,8'ha0,8'h28,8'h78,8'h0a,8'h5a,8'h1e,8'h6e,8'h32,8'h82,8'h14,8'h64,
    8'h64,8'h14,8'h82,8'h32,8'h6e,8'h1e,8'h5a,8'h0a,8'h78,8'h28,8'ha0,8'h50,8'h8c,8'h3c,8'h96,8'h46,
    8'h46,8'h96,8'h0a,8'h5a,8'h3c,8'h8c,8'h14,8'h64,8'h50,8'ha0,8'h28,8'h78,8'h1e,8'h6e,8'h32,8'h82,
    8'h82,8'h32,8'h6e,8'h1e,8'h78,8'h28,8'ha0,8'h50,8'h64,8'h14,8'h8c,8'h3c,8'h5a,8'h0a,8'h96,8'h46,
    8'h46,8'h96,8'h0a,8'h5a,8'h50,8'ha0,8'h3c,8'h8c,8'h28,8'h78,8'h1e,8'h6e,8'h32,8'h82,8'h14,8'h64,
    8'h64,8'h14,8'h82,8'h32,8'h6e,8'h1e,8'h78,8'h28,8'h8c,8'h3c,8'ha0,8'h50,8'h5a,8'h0a,8'h96,8'h46
  };

endpackage

/* rtl/rchpf_lane.sv */
// Stick scaling lane: scale by a constant ratio, truncate, offset and clamp.
module rchpf_lane #(
  parameter int CHAN_MAX = rchpf_pkg::CHAN_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [rchpf_pkg::STICK_W-1:0] stick,
  output logic [15:0]                         word,
  output logic                                on
);
  import rchpf_pkg::*;

  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << MAG_W) / CHAN_MAX);
  localparam logic [CHAN_W-1:0]  CDIV  = CHAN_W'(CHAN_MAX);

  logic [STICK_W-1:0]       s_abs;
  logic [MAG_W-1:0]         mag1, mag2;
  logic                     neg1, neg2, on1, on2;
  logic [MAG_W-1:0]         q2;
  logic [MAG_W+RECIP_W-1:0] prod;
  logic [MAG_W+CHAN_W-1:0]  back;
  logic [MAG_W-1:0]         rem, q;
  logic [MAG_W-1:0]         val;

  assign s_abs = stick[STICK_W-1] ? (~stick + 1'b1) : stick;
  assign prod  = mag1 * RECIP;
  assign back  = q2 * CDIV;
  assign rem   = mag2 - back[MAG_W-1:0];
  assign q     = q2 + MAG_W'(rem >= MAG_W'(CDIV));

  always_comb begin
    if (!neg2) begin
      val = q + STICK_OFS;
    end else if (q > STICK_OFS) begin
      val = '0;
    end else begin
      val = STICK_OFS - q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1 <= MAG_W'(s_abs * SCALE_MUL);
      neg1 <= stick[STICK_W-1];
      on1  <= !stick[STICK_W-1] && (stick != '0);
      mag2 <= mag1;
      neg2 <= neg1;
      on2  <= on1;
      q2   <= prod[MAG_W +: MAG_W];
      word <= val[15:0];
      on   <= on2;
    end
  end

endmodule

/* rtl/rchpf_merge.sv */
// Packet assembly: merge lane words, variant flags, bind and hop state.
module rchpf_merge (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          cfg_we,
  input  logic [rchpf_pkg::CFG_IDX_W-1:0]               cfg_index,
  input  logic [rchpf_pkg::CFG_W-1:0]                   cfg_data,
  input  logic                                          fire,
  input  logic [rchpf_pkg::NUM_LANES-1:0][15:0]         words,
  input  logic [rchpf_pkg::NUM_LANES-1:0]               ons,
  input  logic [rchpf_pkg::SW_W-1:0]                    sw,
  output rchpf_pkg::pkt_t                               pkt
);
  import rchpf_pkg::*;

  logic [31:0]       controller_id;
  logic [1:0]        variant;
  logic [BIND_W-1:0] bind_left;
  logic [HOP_W-1:0]  hop_column;
  logic [31:0]       sent_count;
  logic [SEQ_W-1:0]  frame_seq;

  logic [31:0]       id_adj;
  logic              binding;
  logic [HOP_W-1:0]  hop_column_next;
  logic [31:0]       sent_count_next;
  logic [SEQ_W-1:0]  frame_seq_next;
  logic [7:0]        seq_byte;
  bytes_t            b;

  assign id_adj  = (controller_id[7:4] > ID_NIB_MAX) ? controller_id - 32'(ID_ADJ)
                                                     : controller_id;
  assign binding = bind_left != '0;
  assign hop_column_next = binding ? hop_column : hop_column + 1'b1;
  assign sent_count_next = binding ? sent_count : sent_count + 1'b1;

  always_comb begin
    if (variant != VAR_V912) begin
      frame_seq_next = frame_seq;
    end else if (frame_seq >= SEQ_LAST) begin
      frame_seq_next = '0;
    end else begin
      frame_seq_next = frame_seq + 1'b1;
    end
  end

  always_comb begin
    case (frame_seq_next)
      4'd0:    seq_byte = SEQ_BYTE_0;
      4'd1:    seq_byte = SEQ_BYTE_1;
      4'd2:    seq_byte = SEQ_BYTE_2;
      default: seq_byte = SEQ_BYTE_N;
    endcase
  end

  always_comb begin
    b    = '0;
    b[0] = binding ? HDR_BIND : HDR_DATA;
    b[1] = id_adj[7:0];
    b[2] = id_adj[15:8];
    b[3] = id_adj[23:16];
    b[4] = id_adj[31:24];
    for (int i = 0; i < NUM_LANES; i++) begin
      b[5 + 2 * i] = words[i][7:0];
      b[6 + 2 * i] = words[i][15:8];
    end
    case (variant)
      VAR_V9X9: begin
        b[12] = b[12] | {2'b00, ons[4], ons[7], 4'h0};
        b[10] = b[10] | {ons[6], ons[5], 6'h00};
      end
      VAR_V6X6: begin
        b[13] = {2'b00, sw[0], 5'h00};
        b[14] = {ons[5] | sw[0], ons[4], 1'b0, ons[6], sw[1], sw[2], sw[3], ons[7]};
        b[15] = 8'h10;
        b[16] = 8'h10;
        b[17] = 8'haa;
        b[18] = 8'haa;
        b[19] = 8'h60;
        b[20] = 8'h02;
      end
      VAR_V912: begin
        b[12] = b[12] | 8'h20;
        b[13] = 8'h00;
        b[14] = {ons[4], ons[5], 6'h00};
        b[15] = 8'h27;
        b[16] = 8'h03;
        b[17] = seq_byte;
        b[18] = (frame_seq_next == '0) ? 8'h02 : 8'h00;
        b[19] = 8'h00;
        b[20] = 8'h00;
      end
      default: ;
    endcase
  end

  always_comb begin
    pkt.bytes         = b;
    pkt.binding       = binding;
    pkt.rf_channel    = binding ? BIND_CHAN
                        : HOP_TABLE[{id_adj[3:0], hop_column}] - {4'h0, id_adj[7:4]};
    pkt.refresh_power = !binding && (hop_column_next == '0);
    pkt.packet_count  = sent_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      controller_id <= '0;
      variant       <= VAR_NONE;
      bind_left     <= BIND_DEF;
      hop_column    <= '0;
      sent_count    <= '0;
      frame_seq     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ID:      controller_id <= cfg_data;
        CFG_VARIANT: variant       <= cfg_data[1:0];
        CFG_BIND:    bind_left     <= cfg_data[BIND_W-1:0];
        default: ;
      endcase
    end else if (fire) begin
      bind_left  <= binding ? bind_left - 1'b1 : bind_left;
      hop_column <= hop_column_next;
      sent_count <= sent_count_next;
      frame_seq  <= frame_seq_next;
    end
  end

endmodule

/* rtl/rchpf_ser.sv */
// Packet serializer: one pending packet slot and one output packet slot.
module rchpf_ser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  rchpf_pkg::pkt_t                 in_pkt,
  output logic                            in_ready,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rchpf_pkg::OUT_W-1:0]     m_tdata,
  output logic [rchpf_pkg::USER_W-1:0]    m_tuser,
  output logic                            m_tlast
);
  import rchpf_pkg::*;

  pkt_t             pend, cur;
  logic             pend_valid, cur_valid;
  logic [IDX_W-1:0] idx;
  logic             done, cur_load;

  assign done     = m_tvalid && m_tready && (idx == LAST_IDX);
  assign cur_load = pend_valid && (!cur_valid || done);
  assign in_ready = !pend_valid || cur_load;

  assign m_tvalid = cur_valid;
  assign m_tlast  = idx == LAST_IDX;
  assign m_tdata  = {3'b000, cur.packet_count, cur.rf_channel, idx, cur.bytes[idx]};
  assign m_tuser  = {cur.refresh_power, cur.binding};

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      cur_valid  <= 1'b0;
      idx        <= '0;
    end else begin
      if (in_valid && in_ready) begin
        pend_valid <= 1'b1;
      end else if (cur_load) begin
        pend_valid <= 1'b0;
      end
      if (cur_load) begin
        cur_valid <= 1'b1;
      end else if (done) begin
        cur_valid <= 1'b0;
      end
      if (done) begin
        idx <= '0;
      end else if (m_tvalid && m_tready) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pend <= in_pkt;
    end
    if (cur_load) begin
      cur <= pend;
    end
  end

endmodule

/* rtl/rc_hopping_packet_framer_unit.sv */
// Top level of the hopping packet framer: lanes, merge and serializer.
//
// Usage:
//   Slave stream: one tick beat carries eight 11-bit signed sticks and four
//   extra switch bits. Master stream: each tick yields 21 beats, one packet
//   byte each, with byte index, RF channel and packet count in tdata,
//   bind and power-refresh flags in tuser, and tlast on byte 20.
//   Configuration writes (ID, variant, bind count) go through cfg_we while
//   the block is idle; a bind count write also restarts the bind phase.
//   Path: the tick passes the lane stages, the pending slot and the output
//   slot before its first byte is offered.
//   Throughput: one byte per cycle while tready stays high, set by the
//   serializer; a second tick is taken and assembled while the first is
//   still being sent, and three more wait in the lane pipeline.
//   Reset: synchronous; clears all queued beats, the ID, variant, hop column,
//   sequence and packet count, and reloads the bind count with 2500.
//   Stall: a dropped tready holds the current byte; with the pending slot full,
//   no packet finishing and a tick in the last lane stage, s_tready drops.
module rc_hopping_packet_framer_unit #(
  parameter int CHAN_MAX = rchpf_pkg::CHAN_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // stick_0..stick_7 (11 bits each), extra_switches (4), zero fill
  input  logic [rchpf_pkg::IN_W-1:0]         s_tdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // packet_byte (8), byte_index (5), rf_channel (8), packet_count (32), zero fill
  output logic [rchpf_pkg::OUT_W-1:0]        m_tdata,
  // binding, refresh_power
  output logic [rchpf_pkg::USER_W-1:0]       m_tuser,
  output logic                               m_tlast,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic                               cfg_we,
  input  logic [rchpf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rchpf_pkg::CFG_W-1:0]        cfg_data
);
  import rchpf_pkg::*;

  logic                             v1, v2, v3;
  logic [SW_W-1:0]                  sw1, sw2, sw3;
  logic                             advance, ser_ready;
  logic [NUM_LANES-1:0][15:0]       words;
  logic [NUM_LANES-1:0]             ons;
  pkt_t                             pkt;

  assign advance  = !v3 || ser_ready;
  assign s_tready = advance && !rst;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    rchpf_lane #(.CHAN_MAX(CHAN_MAX)) u_lane (
      .clk   (clk),
      .en    (advance),
      .stick (s_tdata[g*STICK_W +: STICK_W]),
      .word  (words[g]),
      .on    (ons[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sw1 <= s_tdata[NUM_LANES*STICK_W +: SW_W];
      sw2 <= sw1;
      sw3 <= sw2;
    end
  end

  rchpf_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (v3 && ser_ready),
    .words     (words),
    .ons       (ons),
    .sw        (sw3),
    .pkt       (pkt)
  );

  rchpf_ser u_ser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v3),
    .in_pkt   (pkt),
    .in_ready (ser_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

/* rtl/rchpf_checker.sv */
// Port-level checker for the hopping packet framer, bound to the top level.
module rchpf_checker (
  input logic                               clk,
  input logic                               rst,
  input logic [rchpf_pkg::OUT_W-1:0]        m_tdata,
  input logic [rchpf_pkg::USER_W-1:0]       m_tuser,
  input logic                               m_tlast,
  input logic                               m_tvalid,
  input logic                               m_tready
);
  import rchpf_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled beat changed");

  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[12:8] == LAST_IDX)))
    else $error("tlast not on final byte");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && (m_tdata[12:8] == $past(m_tdata[12:8]) + 5'd1))
    else $error("packet bytes not contiguous");

  a_header: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[12:8] == 5'd0) |->
      (m_tdata[7:0] == (m_tuser[0] ? HDR_BIND : HDR_DATA)))
    else $error("header does not match bind flag");

endmodule

bind rc_hopping_packet_framer_unit rchpf_checker u_checker (.*);

/* tb/sv/tb_rc_hopping_packet_framer_unit.sv */
// Self-checking testbench for the hopping packet framer: directed and random ticks.
module tb_rc_hopping_packet_framer_unit;
  import rchpf_pkg::*;

  localparam int FULL_SCALE = CHAN_MAX_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 1000;

  localparam logic [7:0] CHANNEL_MAP [256] = '{
    8'h0a,8'h5a,8'h14,8'h64,8'h1e,8'h6e,8'h28,8'h78,8'h32,8'h82,8'h3c,8'h8c,8'h46,8'h96,8'h50,8'ha0,
    8'ha0,8'h50,8'h96,8'h46,8'h8c,8'h3c,8'h82,8'h32,8'h78,8'h28,8'h6e,8'h1e,8'h64,8'h14,8'h5a,8'h0a,
    8'h0a,8'h5a,8'h50,8'ha0,8'h14,8'h64,8'h46,8'h96,8'h1e,8'h6e,8'h3c,8'h8c,8'h28,8'h78,8'h32,8'h82,
    8'h82,8'h32,8'h78,8'h28,8'h8c,8'h3c,8'h6e,8'h1e,8'h96,8'h46,8'h64,8'h14,8'ha0,8'h50,8'h5a,8'h0a,
    8'h28,8'h78,8'h0a,8'h5a,8'h50,8'ha0,8'h14,8'h64,8'h1e,8'h6e,8'h3c,8'h8c,8'h32,8'h82,8'h46,8'h96,
    8'h96,8'h46,8'h82,8'h32,8'h8c,8'h3c,8'h6e,8'h1e,8'h64,8'h14,8'ha0,8'h50,8'h5a,8'h0a,8'h78,8'h28,
    8'h50,8'ha0,8'h28,8'h78,8'h0a,8'h5a,8'h1e,8'h6e,8'h3c,8'h8c,8'h32,8'h82,8'h46,8'h96,8'h14,8'h64,
    8'h64,8'h14,8'h96,8'h46,8'h82,8'h32,8'h8c,8'h3c,8'h6e,8'h1e,8'h5a,8'h0a,8'h78,8'h28,8'ha0,8'h50,
    8'h50,8'ha0,8'h46,8'h96,8'h3c,8'h8c,8'h28,8'h78,8'h0a,8'h5a,8'h32,8'h82,8'h1e,8'h6e,8'h14,8'h64,
    8'h64,8'h14,8'h6e,8'h1e,8'h82,8'h32,8'h5a,8'h0a,8'h78,8'h28,8'h8c,8'h3c,8'h96,8'h46,8'ha0,8'h50,
    8'h46,8'h96,8'h3c,8'h8c,8'h50,8'ha0,8'h28,8'h78,8'h0a,8'h5a,8'h1e,8'h6e,8'h32,8'h82,8'h14,8'h64,
    8'h64,8'h14,8'h82,8'h32,8'h6e,8'h1e,8'h5a,8'h0a,8'h78,8'h28,8'ha0,8'h50,8'h8c,8'h3c,8'h96,8'h46,
    8'h46,8'h96,8'h0a,8'h5a,8'h3c,8'h8c,8'h14,8'h64,8'h50,8'ha0,8'h28,8'h78,8'h1e,8'h6e,8'h32,8'h82,
    8'h82,8'h32,8'h6e,8'h1e,8'h78,8'h28,8'ha0,8'h50,8'h64,8'h14,8'h8c,8'h3c,8'h5a,8'h0a,8'h96,8'h46,
    8'h46,8'h96,8'h0a,8'h5a,8'h50,8'ha0,8'h3c,8'h8c,8'h28,8'h78,8'h1e,8'h6e,8'h32,8'h82,8'h14,8'h64,
    8'h64,8'h14,8'h82,8'h32,8'h6e,8'h1e,8'h78,8'h28,8'h8c,8'h3c,8'ha0,8'h50,8'h5a,8'h0a,8'h96,8'h46
  };

  localparam logic [7:0] SEQ_CODES [10] = '{
    8'h14, 8'h31, 8'h40, 8'h49, 8'h49, 8'h49, 8'h49, 8'h49, 8'h49, 8'h49
  };

  typedef struct {
    logic [7:0]  data;
    logic [4:0]  pos;
    logic [7:0]  chan;
    logic        binding;
    logic        refresh;
    logic [31:0] count;
    logic        last;
  } pkt_byte_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic [IN_W-1:0]      s_tdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [OUT_W-1:0]     m_tdata;
  logic [USER_W-1:0]    m_tuser;
  logic                 m_tlast;
  logic                 m_tvalid;
  logic                 m_tready = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // predictor state
  logic [31:0]     id_reg = '0;
  logic [1:0]      variant_reg = VAR_NONE;
  logic [BIND_W-1:0] bind_left = BIND_DEF;
  logic [HOP_W-1:0]  hop_col = '0;
  logic [31:0]     sent_cnt = '0;
  logic [SEQ_W-1:0]  seq = '0;

  pkt_byte_t byte_q [$];
  int errors = 0;
  int stall_cycles = 0;
  int hold_left = 0;
  bit idle_en = 1'b1;

  rc_hopping_packet_framer_unit dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  task automatic frame_tick(input logic [7:0][10:0] st, input logic [3:0] sw);
    logic [7:0]  pkt [PACKET_BYTES];
    logic [31:0] aid;
    logic [11:0] on;
    logic [7:0]  chan;
    logic        binding;
    logic        refresh;
    int          s;
    int          v;
    pkt_byte_t   e;
    aid = (id_reg[7:4] > 4'h9) ? id_reg - 32'h70 : id_reg;
    binding = bind_left != '0;
    refresh = 1'b0;
    foreach (pkt[i]) pkt[i] = 8'h00;
    pkt[0] = binding ? HDR_BIND : HDR_DATA;
    pkt[1] = aid[7:0];
    pkt[2] = aid[15:8];
    pkt[3] = aid[23:16];
    pkt[4] = aid[31:24];
    for (int i = 0; i < 8; i++) begin
      s = $signed(st[i]);
      v = s * SCALE_MUL / FULL_SCALE + 32'sh5d9;
      if (v < 0) v = 0;
      on[i] = s > 0;
      pkt[5 + 2 * i] = v[7:0];
      pkt[6 + 2 * i] = v[15:8];
    end
    on[11:8] = sw;
    case (variant_reg)
      VAR_V9X9: begin
        if (on[4]) pkt[12] |= 8'h20;
        if (on[5]) pkt[10] |= 8'h40;
        if (on[6]) pkt[10] |= 8'h80;
        if (on[7]) pkt[12] |= 8'h10;
      end
      VAR_V6X6: begin
        pkt[13] = 8'h00;
        pkt[14] = 8'h00;
        if (on[4]) pkt[14] |= 8'h40;
        if (on[5]) pkt[14] |= 8'h80;
        if (on[6]) pkt[14] |= 8'h10;
        if (on[7]) pkt[14] |= 8'h01;
        if (on[8]) begin
          pkt[14] |= 8'h80;
          pkt[13] |= 8'h20;
        end
        if (on[9]) pkt[14] |= 8'h08;
        if (on[10]) pkt[14] |= 8'h04;
        if (on[11]) pkt[14] |= 8'h02;
        pkt[15] = 8'h10;
        pkt[16] = 8'h10;
        pkt[17] = 8'hAA;
        pkt[18] = 8'hAA;
        pkt[19] = 8'h60;
        pkt[20] = 8'h02;
      end
      VAR_V912: begin
        seq = (seq >= 4'd9) ? 4'd0 : seq + 4'd1;
        pkt[12] |= 8'h20;
        pkt[13] = 8'h00;
        pkt[14] = 8'h00;
        if (on[4]) pkt[14] |= 8'h80;
        if (on[5]) pkt[14] |= 8'h40;
        pkt[15] = 8'h27;
        pkt[16] = 8'h03;
        pkt[17] = SEQ_CODES[seq];
        pkt[18] = (seq == 4'd0) ? 8'h02 : 8'h00;
        pkt[19] = 8'h00;
        pkt[20] = 8'h00;
      end
      default: ;
    endcase
    if (binding) begin
      chan = BIND_CHAN;
      bind_left = bind_left - 1'b1;
    end else begin
      chan = CHANNEL_MAP[{aid[3:0], hop_col}] - {4'h0, aid[7:4]};
      hop_col = hop_col + 1'b1;
      refresh = hop_col == '0;
      sent_cnt = sent_cnt + 32'd1;
    end
    for (int i = 0; i < PACKET_BYTES; i++) begin
      e.data = pkt[i];
      e.pos = 5'(i);
      e.chan = chan;
      e.binding = binding;
      e.refresh = refresh;
      e.count = sent_cnt;
      e.last = i == PACKET_BYTES - 1;
      byte_q.push_back(e);
    end
  endtask

  task automatic send_tick(input logic [7:0][10:0] st, input logic [3:0] sw);
    int gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata = {4'h0, sw, st};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    frame_tick(st, sw);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (byte_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    case (idx)
      CFG_ID:      id_reg = value;
      CFG_VARIANT: variant_reg = value[1:0];
      CFG_BIND:    bind_left = value[BIND_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  function automatic logic [7:0][10:0] random_sticks();
    logic [7:0][10:0] st;
    for (int i = 0; i < 8; i++) st[i] = 11'($urandom_range(0, 2047));
    return st;
  endfunction

  // sink side: random stall bursts
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready = 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(0, 3);
      m_tready = 1'b0;
    end else begin
      m_tready = 1'b1;
    end
  end

  always @(posedge clk) begin : packet_monitor
    pkt_byte_t e;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (byte_q.size() == 0) begin
        $error("packet_byte: expected none, got %0h", m_tdata[7:0]);
        errors++;
      end else begin
        e = byte_q.pop_front();
        check_field("packet_byte", e.data, m_tdata[7:0]);
        check_field("byte_index", e.pos, m_tdata[12:8]);
        check_field("rf_channel", e.chan, m_tdata[20:13]);
        check_field("packet_count", e.count, m_tdata[52:21]);
        check_field("binding", e.binding, m_tuser[0]);
        check_field("refresh_power", e.refresh, m_tuser[1]);
        check_field("last_byte", e.last, m_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid === 1'b1 && m_tready) || cfg_we)
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("rc_hopping_packet_framer_unit verification failed");
      $finish;
    end
  end

  task automatic test_bind_default();
    send_tick({8{11'h400}}, 4'h0);
    send_tick({8{11'h3ff}}, 4'hf);
  endtask

  task automatic test_registers();
    wait_idle();
    write_reg(CFG_UNUSED, 32'hffff_ffff);
    write_reg(CFG_ID, 32'hffff_ffff);
    write_reg(CFG_BIND, 32'h0000_0fff);
    send_tick({11'h418, 11'h3e8, 11'h000, 11'h7ff, 11'h001, 11'h400, 11'h3ff, 11'h418},
              4'ha);
    wait_idle();
    write_reg(CFG_ID, 32'h0000_0000);
    write_reg(CFG_BIND, 32'h0000_0000);
    send_tick({11'h3e8, 11'h418, 11'h001, 11'h000, 11'h3ff, 11'h400, 11'h7ff, 11'h3e8},
              4'h5);
  endtask

  task automatic test_variants();
    logic [7:0][10:0] st;
    for (int k = 0; k < 4; k++) begin
      wait_idle();
      write_reg(CFG_VARIANT, 32'(k));
      st = random_sticks();
      st[7:4] = {4{11'h001}};
      send_tick(st, 4'hf);
      st = random_sticks();
      st[7:4] = {4{11'h7ff}};
      send_tick(st, 4'h0);
    end
  endtask

  task automatic test_hop_id();
    wait_idle();
    write_reg(CFG_VARIANT, VAR_NONE);
    write_reg(CFG_ID, 32'h0000_00a3);
    write_reg(CFG_BIND, 32'd1);
    repeat (3) send_tick(random_sticks(), 4'($urandom_range(0, 15)));
    wait_idle();
    write_reg(CFG_ID, 32'h1234_5690);
    repeat (2) send_tick(random_sticks(), 4'($urandom_range(0, 15)));
  endtask

  task automatic test_random();
    logic [31:0] id;
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      idle_en = ph < 5;
      id = $urandom;
      if ($urandom_range(0, 1) == 0) id[7:4] = 4'($urandom_range(10, 15));
      write_reg(CFG_ID, id);
      write_reg(CFG_VARIANT, ph < 4 ? 32'(ph) : 32'($urandom_range(0, 3)));
      write_reg(CFG_BIND, $urandom_range(0, 7) == 0 ? 32'($urandom_range(0, 4095))
                                                 : 32'($urandom_range(0, 5)));
      if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED, $urandom);
      repeat (17) send_tick(random_sticks(), 4'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_bind_default();
    test_registers();
    test_variants();
    test_hop_id();
    test_random();
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("rc_hopping_packet_framer_unit verification clean");
    else
      $display("rc_hopping_packet_framer_unit verification failed");
    $finish;
  end

endmodule
